// File: rtl/fmrdb_pkg.sv
// ----------------------------------------------------------------------------
// fmrdb_pkg
// Shared widths, fixed-point constants and codes of the filter magnitude
// response unit.
// ----------------------------------------------------------------------------
package fmrdb_pkg;

  // field widths
  localparam int unsigned ProbeW = 19;
  localparam int unsigned LevelW = 16;
  localparam int unsigned FamW   = 3;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned DbW    = 16;

  // internal value widths
  localparam int unsigned QW    = 19;  // q in Q.15, up to 12.0
  localparam int unsigned RW    = 32;  // clamped ratio, Q.22
  localparam int unsigned R2W   = 42;  // ratio squared, Q.22
  localparam int unsigned BW    = 34;  // ratio over q, Q.22
  localparam int unsigned ShW   = 4;   // normalizing shift, 0..11
  localparam int unsigned MantW = 31;  // log mantissa, Q1.30

  localparam int unsigned RFrac   = 22;
  localparam int unsigned LogFrac = 16;

  localparam logic [RW-1:0]     RMin     = 32'd4194;
  localparam logic [RW-1:0]     RMax     = 32'd4194304000;
  localparam logic [ProbeW-1:0] CutMin   = 19'd80;
  localparam logic [ProbeW-1:0] CutMax   = 19'd320000;
  localparam logic [LevelW-1:0] LevelMax = 16'd32768;

  localparam logic [QW-1:0] QBaseSvf    = 19'd16384;
  localparam logic [QW-1:0] QBaseLadder = 19'd19661;
  localparam logic [QW-1:0] QBaseOther  = 19'd22938;
  localparam logic [QW-1:0] QMax        = 19'd393216;

  // 10*log10(2) in Q.24
  localparam logic signed [26:0] DbScale = 27'sd50504453;
  // -100 dB in Q8.8
  localparam logic signed [21:0] DbFloor = -22'sd25600;

  typedef enum logic [2:0] {
    RegCutoff    = 3'd0,
    RegResonance = 3'd1,
    RegDrive     = 3'd2,
    RegFamily    = 3'd3,
    RegMode      = 3'd4,
    RegSteep     = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    FamSvf       = 3'd0,
    FamLadder    = 3'd1,
    FamKType     = 3'd2,
    FamOType     = 3'd3,
    FamSallenKey = 3'd4
  } family_e;

  typedef enum logic [1:0] {
    KindLp    = 2'd0,
    KindBp    = 2'd1,
    KindHp    = 2'd2,
    KindNotch = 2'd3
  } kind_e;

  // floor(x / 5) for x below 2^22, by reciprocal multiply
  function automatic logic [21:0] div5(input logic [21:0] x);
    logic [42:0] p;
    p = 43'(x) * 43'd1677722;
    return {2'b00, p[42:23]};
  endfunction

endpackage

// File: rtl/fmrdb_div.sv
// ----------------------------------------------------------------------------
// fmrdb_div
// Pipelined restoring divider: a few quotient bits per stage, with a
// sideband that travels with each beat.
// ----------------------------------------------------------------------------
module fmrdb_div #(
  parameter int unsigned NumW         = 41,
  parameter int unsigned DenW         = 19,
  parameter int unsigned BitsPerStage = 4,
  parameter int unsigned SideW        = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [NumW-1:0]  quot_o,
  output logic [SideW-1:0] side_o
);

  localparam int unsigned NumStages = (NumW + BitsPerStage - 1) / BitsPerStage;
  localparam int unsigned PadW      = NumStages * BitsPerStage;

  logic             valid_q [NumStages];
  logic [DenW-1:0]  rem_q   [NumStages];
  logic [PadW-1:0]  work_q  [NumStages];
  logic [SideW-1:0] side_q  [NumStages];

  for (genvar g = 0; g < NumStages; g++) begin : g_stage
    logic             st_valid;
    logic [DenW-1:0]  st_rem;
    logic [PadW-1:0]  st_work;
    logic [SideW-1:0] st_side;
    logic [DenW-1:0]  rem_d;
    logic [PadW-1:0]  work_d;

    if (g == 0) begin : g_first
      assign st_valid = valid_i;
      assign st_rem   = '0;
      assign st_work  = PadW'(num_i);
      assign st_side  = side_i;
    end else begin : g_next
      assign st_valid = valid_q[g-1];
      assign st_rem   = rem_q[g-1];
      assign st_work  = work_q[g-1];
      assign st_side  = side_q[g-1];
    end

    // shift numerator bits into the remainder, quotient bits in at the bottom
    always_comb begin
      logic [DenW:0] trial;
      rem_d  = st_rem;
      work_d = st_work;
      for (int i = 0; i < BitsPerStage; i++) begin
        trial  = {rem_d, work_d[PadW-1]};
        work_d = {work_d[PadW-2:0], 1'b0};
        if (trial >= {1'b0, den_i}) begin
          rem_d     = DenW'(trial - {1'b0, den_i});
          work_d[0] = 1'b1;
        end else begin
          rem_d = trial[DenW-1:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else if (en_i) begin
        valid_q[g] <= st_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= rem_d;
        work_q[g] <= work_d;
        side_q[g] <= st_side;
      end
    end
  end

  assign valid_o = valid_q[NumStages-1];
  assign quot_o  = work_q[NumStages-1][NumW-1:0];
  assign side_o  = side_q[NumStages-1];

endmodule

// File: rtl/fmrdb_log.sv
// ----------------------------------------------------------------------------
// fmrdb_log
// Pipelined base-2 logarithm of two operands in lockstep: one normalize
// stage, then one mantissa squaring per fraction bit.
// ----------------------------------------------------------------------------
module fmrdb_log #(
  parameter int unsigned XW    = 64,
  parameter int unsigned SideW = 5
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  logic                                    valid_i,
  input  logic [XW-1:0]                           xa_i,
  input  logic [XW-1:0]                           xb_i,
  input  logic [SideW-1:0]                        side_i,
  output logic                                    valid_o,
  output logic [$clog2(XW)+fmrdb_pkg::LogFrac-1:0] la_o,
  output logic [$clog2(XW)+fmrdb_pkg::LogFrac-1:0] lb_o,
  output logic [SideW-1:0]                        side_o
);

  localparam int unsigned ExpW      = $clog2(XW);
  localparam int unsigned MantW     = fmrdb_pkg::MantW;
  localparam int unsigned FracW     = fmrdb_pkg::LogFrac;
  localparam int unsigned NumStages = FracW + 1;

  logic             valid_q [NumStages];
  logic [ExpW-1:0]  ea_q    [NumStages];
  logic [ExpW-1:0]  eb_q    [NumStages];
  logic [MantW-1:0] ma_q    [NumStages];
  logic [MantW-1:0] mb_q    [NumStages];
  logic [FracW-1:0] fa_q    [NumStages];
  logic [FracW-1:0] fb_q    [NumStages];
  logic [SideW-1:0] side_q  [NumStages];

  // leading one and normalization to Q1.30
  logic [ExpW-1:0]  ea_d, eb_d;
  logic [XW-1:0]    sha, shb;

  always_comb begin
    ea_d = '0;
    eb_d = '0;
    for (int i = 0; i < XW; i++) begin
      if (xa_i[i]) ea_d = ExpW'(i);
      if (xb_i[i]) eb_d = ExpW'(i);
    end
    sha = xa_i << (ExpW'(XW - 1) - ea_d);
    shb = xb_i << (ExpW'(XW - 1) - eb_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ea_q[0]   <= ea_d;
      eb_q[0]   <= eb_d;
      ma_q[0]   <= sha[XW-1 -: MantW];
      mb_q[0]   <= shb[XW-1 -: MantW];
      fa_q[0]   <= '0;
      fb_q[0]   <= '0;
      side_q[0] <= side_i;
    end
  end

  for (genvar g = 1; g < NumStages; g++) begin : g_sq
    logic [2*MantW-1:0] sqa, sqb;
    logic [MantW:0]     ta, tb;
    logic [MantW-1:0]   ma_d, mb_d;

    // square, and renormalize when the square reaches two
    always_comb begin
      sqa  = (2*MantW)'(ma_q[g-1]) * (2*MantW)'(ma_q[g-1]);
      sqb  = (2*MantW)'(mb_q[g-1]) * (2*MantW)'(mb_q[g-1]);
      ta   = sqa[2*MantW-1 : MantW-1];
      tb   = sqb[2*MantW-1 : MantW-1];
      ma_d = ta[MantW] ? ta[MantW:1] : ta[MantW-1:0];
      mb_d = tb[MantW] ? tb[MantW:1] : tb[MantW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else if (en_i) begin
        valid_q[g] <= valid_q[g-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ea_q[g]   <= ea_q[g-1];
        eb_q[g]   <= eb_q[g-1];
        ma_q[g]   <= ma_d;
        mb_q[g]   <= mb_d;
        fa_q[g]   <= {fa_q[g-1][FracW-2:0], ta[MantW]};
        fb_q[g]   <= {fb_q[g-1][FracW-2:0], tb[MantW]};
        side_q[g] <= side_q[g-1];
      end
    end
  end

  assign valid_o = valid_q[NumStages-1];
  assign la_o    = {ea_q[NumStages-1], fa_q[NumStages-1]};
  assign lb_o    = {eb_q[NumStages-1], fb_q[NumStages-1]};
  assign side_o  = side_q[NumStages-1];

endmodule

// File: rtl/filter_magnitude_response_db_unit.sv
// ----------------------------------------------------------------------------
// filter_magnitude_response_db_unit
// Magnitude response in dB of an idealized two-pole filter at one probe
// frequency per beat.
// ----------------------------------------------------------------------------
// Each input beat carries one probe frequency (1/16 Hz); each output beat
// carries the response in signed Q8.8 dB. The unit is a fully pipelined
// datapath: a new beat enters every cycle while the output beat is not stalled.
// The two dividers (probe over cutoff, ratio over Q) each retire DivBits
// (default 4) quotient bits per stage, and the logarithm has 17 stages.
// When the output beat is stalled the whole pipeline holds, bubbles
// included, and in_stall_o follows. Registers must be written over the APB
// port only while no beat is in flight; the block itself does not enforce
// this. The derived Q is re-registered in the cycle after a write.
// ----------------------------------------------------------------------------
module filter_magnitude_response_db_unit #(
  parameter int unsigned DivBits = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // probe channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [fmrdb_pkg::ProbeW-1:0] probe_freq_i,
  // response channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [fmrdb_pkg::DbW-1:0] response_db_o,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [4:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int unsigned ProbeW = fmrdb_pkg::ProbeW;
  localparam int unsigned LevelW = fmrdb_pkg::LevelW;
  localparam int unsigned QW     = fmrdb_pkg::QW;
  localparam int unsigned RW     = fmrdb_pkg::RW;
  localparam int unsigned R2W    = fmrdb_pkg::R2W;
  localparam int unsigned BW     = fmrdb_pkg::BW;
  localparam int unsigned ShW    = fmrdb_pkg::ShW;
  localparam int unsigned MantW  = fmrdb_pkg::MantW;
  localparam int unsigned RFrac  = fmrdb_pkg::RFrac;
  localparam int unsigned Num1W  = ProbeW + RFrac;   // probe << 22
  localparam int unsigned Num2W  = RW + 16;          // (r << 15) + q/2
  localparam int unsigned D2W    = 2 * MantW + 1;
  localparam int unsigned LogXW  = 64;
  localparam int unsigned LogW   = $clog2(LogXW) + fmrdb_pkg::LogFrac;

  // --------------------------------------------------------------------------
  // Register file
  // --------------------------------------------------------------------------
  logic [ProbeW-1:0]           cutoff_q;
  logic [LevelW-1:0]           resonance_q;
  logic [LevelW-1:0]           drive_q;
  logic [fmrdb_pkg::FamW-1:0]  family_q;
  logic [fmrdb_pkg::ModeW-1:0] mode_q;
  logic                        steep_q;
  logic                        wr_en;
  fmrdb_pkg::reg_idx_e         reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = fmrdb_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q    <= 19'd16000;
      resonance_q <= '0;
      drive_q     <= '0;
      family_q    <= '0;
      mode_q      <= '0;
      steep_q     <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        fmrdb_pkg::RegCutoff:    cutoff_q    <= pwdata[ProbeW-1:0];
        fmrdb_pkg::RegResonance: resonance_q <= pwdata[LevelW-1:0];
        fmrdb_pkg::RegDrive:     drive_q     <= pwdata[LevelW-1:0];
        fmrdb_pkg::RegFamily:    family_q    <= pwdata[fmrdb_pkg::FamW-1:0];
        fmrdb_pkg::RegMode:      mode_q      <= pwdata[fmrdb_pkg::ModeW-1:0];
        fmrdb_pkg::RegSteep:     steep_q     <= pwdata[0];
        default: ;  // drop writes to unmapped addresses
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      fmrdb_pkg::RegCutoff:    prdata = 32'(cutoff_q);
      fmrdb_pkg::RegResonance: prdata = 32'(resonance_q);
      fmrdb_pkg::RegDrive:     prdata = 32'(drive_q);
      fmrdb_pkg::RegFamily:    prdata = 32'(family_q);
      fmrdb_pkg::RegMode:      prdata = 32'(mode_q);
      fmrdb_pkg::RegSteep:     prdata = 32'(steep_q);
      default:                 prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Register-derived settings (user keeps them stable while beats are in flight)
  // --------------------------------------------------------------------------
  logic [ProbeW-1:0]   cut_eff;
  logic [LevelW-1:0]   res_eff;
  logic [LevelW-1:0]   drv_eff;
  fmrdb_pkg::family_e  fam_eff;
  fmrdb_pkg::kind_e    kind;
  logic [1:0]          kshift;
  logic [10:0]         trim;
  logic [18:0]         trim_full;
  logic [QW-1:0]       q_d, q_q;

  always_comb begin
    cut_eff = cutoff_q;
    if (cutoff_q < fmrdb_pkg::CutMin) cut_eff = fmrdb_pkg::CutMin;
    if (cutoff_q > fmrdb_pkg::CutMax) cut_eff = fmrdb_pkg::CutMax;
    res_eff = (resonance_q > fmrdb_pkg::LevelMax) ? fmrdb_pkg::LevelMax : resonance_q;
    drv_eff = (drive_q > fmrdb_pkg::LevelMax) ? fmrdb_pkg::LevelMax : drive_q;
    fam_eff = (family_q > 3'(fmrdb_pkg::FamSallenKey)) ? fmrdb_pkg::FamSallenKey
                                                       : fmrdb_pkg::family_e'(family_q);
  end

  // map mode to response type per family
  always_comb begin
    case (fam_eff)
      fmrdb_pkg::FamLadder: kind = fmrdb_pkg::KindLp;
      fmrdb_pkg::FamKType:
        kind = (mode_q == 2'd1) ? fmrdb_pkg::KindHp : fmrdb_pkg::KindLp;
      fmrdb_pkg::FamSallenKey: begin
        if (mode_q == 2'd1)      kind = fmrdb_pkg::KindBp;
        else if (mode_q == 2'd2) kind = fmrdb_pkg::KindHp;
        else                     kind = fmrdb_pkg::KindLp;
      end
      default: kind = fmrdb_pkg::kind_e'(mode_q);
    endcase
  end

  // ladder lowpass squares the magnitude, steep slope squares it again
  assign kshift    = 2'(fam_eff == fmrdb_pkg::FamLadder) + 2'(steep_q);
  assign trim_full = 19'(drv_eff) * 19'd5 + 19'd128;
  assign trim      = trim_full[18:8];

  // Q in Q.15, rounded half up
  always_comb begin
    case (fam_eff)
      fmrdb_pkg::FamSvf: begin
        q_d = fmrdb_pkg::QBaseSvf + QW'((22'(res_eff) * 22'd23 + 22'd1) >> 1);
      end
      fmrdb_pkg::FamLadder: begin
        q_d = fmrdb_pkg::QBaseLadder
            + QW'(fmrdb_pkg::div5(22'(res_eff) * 22'd47 + 22'd2));
      end
      default: begin
        q_d = fmrdb_pkg::QBaseOther
            + QW'(fmrdb_pkg::div5((22'(res_eff) * 22'd93 + 22'd5) >> 1));
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  // --------------------------------------------------------------------------
  // Flow control: hold every stage while the output beat is stalled
  // --------------------------------------------------------------------------
  logic en;
  logic out_valid_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // --------------------------------------------------------------------------
  // Ratio r = probe * 2^22 / cutoff
  // --------------------------------------------------------------------------
  logic             d1_valid;
  logic [Num1W-1:0] d1_quot;
  logic             d1_zero;

  fmrdb_div #(
    .NumW(Num1W), .DenW(ProbeW), .BitsPerStage(DivBits), .SideW(1)
  ) u_div_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .num_i   ({probe_freq_i, {RFrac{1'b0}}}),
    .den_i   (cut_eff),
    .side_i  (probe_freq_i == '0),
    .valid_o (d1_valid),
    .quot_o  (d1_quot),
    .side_o  (d1_zero)
  );

  // clamp stage
  logic          vc_q;
  logic [RW-1:0] r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_q <= 1'b0;
    else if (en) vc_q <= d1_valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (d1_zero || d1_quot < Num1W'(fmrdb_pkg::RMin)) r_q <= fmrdb_pkg::RMin;
      else if (d1_quot > Num1W'(fmrdb_pkg::RMax))       r_q <= fmrdb_pkg::RMax;
      else                                              r_q <= d1_quot[RW-1:0];
    end
  end

  // square stage: r2 and the numerator of r/q
  logic             vm_q;
  logic [R2W-1:0]   r2_q;
  logic [Num2W-1:0] n2_q;
  logic [63:0]      rsq;

  assign rsq = 64'(r_q) * 64'(r_q) + (64'd1 << (RFrac - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vm_q <= 1'b0;
    else if (en) vm_q <= vc_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_q <= rsq[63:RFrac];
      n2_q <= Num2W'({r_q, 15'b0}) + Num2W'(q_q[QW-1:1]);
    end
  end

  // --------------------------------------------------------------------------
  // b = r / q
  // --------------------------------------------------------------------------
  logic             d2_valid;
  logic [Num2W-1:0] d2_quot;
  logic [R2W-1:0]   d2_r2;

  fmrdb_div #(
    .NumW(Num2W), .DenW(QW), .BitsPerStage(DivBits), .SideW(R2W)
  ) u_div_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vm_q),
    .num_i   (n2_q),
    .den_i   (q_q),
    .side_i  (r2_q),
    .valid_o (d2_valid),
    .quot_o  (d2_quot),
    .side_o  (d2_r2)
  );

  // --------------------------------------------------------------------------
  // Denominator terms and numerator select
  // --------------------------------------------------------------------------
  localparam logic [R2W-1:0] One = R2W'(1) << RFrac;

  logic           va_q;
  logic [R2W-1:0] a_q, num_q;
  logic [BW-1:0]  b_q;
  logic [R2W-1:0] a_d, num_d;

  always_comb begin
    a_d = (d2_r2 >= One) ? d2_r2 - One : One - d2_r2;
    case (kind)
      fmrdb_pkg::KindBp:    num_d = R2W'(d2_quot[BW-1:0]);
      fmrdb_pkg::KindHp:    num_d = d2_r2;
      fmrdb_pkg::KindNotch: num_d = a_d;
      default:              num_d = One;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else if (en) va_q <= d2_valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q   <= a_d;
      b_q   <= d2_quot[BW-1:0];
      num_q <= num_d;
    end
  end

  // normalize stage: bring max(a, b) below 2^31
  logic             vs_q;
  logic [MantW-1:0] as_q, bs_q;
  logic [ShW-1:0]   s_q;
  logic [R2W-1:0]   nums_q;
  logic [R2W-1:0]   mx, a_sh, b_sh;
  logic [ShW-1:0]   s_d;

  always_comb begin
    mx  = (a_q > R2W'(b_q)) ? a_q : R2W'(b_q);
    s_d = '0;
    for (int i = MantW; i < R2W; i++) begin
      if (mx[i]) s_d = ShW'(i - MantW + 1);
    end
    a_sh = a_q >> s_d;
    b_sh = R2W'(b_q) >> s_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vs_q <= 1'b0;
    else if (en) vs_q <= va_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      as_q   <= a_sh[MantW-1:0];
      bs_q   <= b_sh[MantW-1:0];
      s_q    <= s_d;
      nums_q <= num_q;
    end
  end

  // sum of squares
  logic           vq_q;
  logic [D2W-1:0] d2_q;
  logic [R2W-1:0] numq_q;
  logic [ShW-1:0] sq_q;
  logic           nzq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vq_q <= 1'b0;
    else if (en) vq_q <= vs_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_q   <= D2W'(as_q) * D2W'(as_q) + D2W'(bs_q) * D2W'(bs_q);
      numq_q <= nums_q;
      sq_q   <= s_q;
      nzq_q  <= (nums_q == '0);
    end
  end

  // --------------------------------------------------------------------------
  // log2 of numerator and of denominator squared
  // --------------------------------------------------------------------------
  logic           lg_valid;
  logic [LogW-1:0] lg_num, lg_den;
  logic [ShW:0]   lg_side;

  fmrdb_log #(
    .XW(LogXW), .SideW(ShW + 1)
  ) u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vq_q),
    .xa_i    (LogXW'(numq_q)),
    .xb_i    (LogXW'(d2_q)),
    .side_i  ({sq_q, nzq_q}),
    .valid_o (lg_valid),
    .la_o    (lg_num),
    .lb_o    (lg_den),
    .side_o  (lg_side)
  );

  // --------------------------------------------------------------------------
  // dB conversion, floor, trim, saturation
  // --------------------------------------------------------------------------
  logic               vt_q, nzt_q;
  logic signed [24:0] twol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vt_q <= 1'b0;
    else if (en) vt_q <= lg_valid;
  end

  // twice log2 of the magnitude, Q.16
  always_ff @(posedge clk_i) begin
    if (en) begin
      twol_q <= $signed({2'b00, lg_num, 1'b0}) - $signed({3'b000, lg_den})
              - $signed({4'b0000, lg_side[ShW:1], 17'b0});
      nzt_q  <= lg_side[0];
    end
  end

  logic               vp_q, nzp_q;
  logic signed [53:0] prod_q;
  logic signed [51:0] prod;

  assign prod = 52'(twol_q) * 52'(fmrdb_pkg::DbScale);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vp_q <= 1'b0;
    else if (en) vp_q <= vt_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= 54'(prod) <<< kshift;
      nzp_q  <= nzt_q;
    end
  end

  // divide by 2^32, ties away from zero
  logic               vr_q, nzr_q;
  logic signed [21:0] db_q;
  logic signed [53:0] rnd;

  assign rnd = prod_q + (prod_q[53] ? 54'sd2147483647 : 54'sd2147483648);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vr_q <= 1'b0;
    else if (en) vr_q <= vp_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      db_q  <= rnd[53:32];
      nzr_q <= nzp_q;
    end
  end

  // output register
  logic signed [21:0]  db_fl;
  logic signed [22:0]  db_tr;
  logic signed [15:0]  db_sat;
  logic signed [15:0]  resp_q;

  always_comb begin
    if (nzr_q || db_q < fmrdb_pkg::DbFloor) db_fl = fmrdb_pkg::DbFloor;
    else                                    db_fl = db_q;
    db_tr = 23'(db_fl) - $signed({12'b0, trim});
    if (db_tr > 23'sd32767)       db_sat = 16'sh7fff;
    else if (db_tr < -23'sd32768) db_sat = -16'sh8000;
    else                          db_sat = db_tr[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= vr_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) resp_q <= db_sat;
  end

  assign out_valid_o   = out_valid_q;
  assign response_db_o = resp_q;

`ifndef SYNTHESIS
  a_ratio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc_q |-> (r_q >= fmrdb_pkg::RMin && r_q <= fmrdb_pkg::RMax))
    else $error("clamped ratio out of range");

  a_q_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vm_q |-> (q_q >= fmrdb_pkg::QBaseSvf && q_q <= fmrdb_pkg::QMax))
    else $error("derived Q out of range");

  a_out_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (response_db_o >= -16'sd26240))
    else $error("response below floor minus maximum trim");

  a_notch_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && vr_q && nzr_q) |=>
      (out_valid_o && 23'(response_db_o) == 23'(fmrdb_pkg::DbFloor) - $signed({12'b0, trim})))
    else $error("notch null did not give the floor level");
`endif

endmodule
